// ===== rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Types, constants and helpers shared by the parameter record checker.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Record layout
  localparam int unsigned RecBytes = 32;
  localparam int unsigned CrcBytes = 24;
  localparam int unsigned PosW     = 6;

  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0] RecMagic   = 32'h3150_4656;
  localparam logic [15:0] RecVersion = 16'h0001;
  localparam logic [15:0] RecSize    = 16'd32;
  localparam logic [15:0] CommitA    = 16'h5AA5;
  localparam logic [15:0] CommitB    = 16'hA55A;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgMaxFreq = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgMinTemp = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxTemp = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxMode = 4'd3;

  typedef enum logic [2:0] {
    StOk           = 3'd0,
    StBadFormat    = 3'd1,
    StNotCommitted = 3'd2,
    StCrcError     = 3'd3,
    StBadParam     = 3'd4
  } status_e;

  // Parameter limits
  typedef struct packed {
    logic        [15:0] max_freq;
    logic signed [15:0] min_temp;
    logic signed [15:0] max_temp;
    logic        [7:0]  max_mode;
  } limits_t;

  // One result item
  typedef struct packed {
    status_e            status;
    logic        [15:0] frequency;
    logic signed [15:0] temperature;
    logic        [7:0]  mode;
    logic        [31:0] generation;
  } result_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Expected value of a fixed header or commit byte
  function automatic logic [7:0] fixed_byte(input logic [4:0] pos);
    logic [7:0] v;
    unique case (pos)
      5'd0:    v = RecMagic[7:0];
      5'd1:    v = RecMagic[15:8];
      5'd2:    v = RecMagic[23:16];
      5'd3:    v = RecMagic[31:24];
      5'd4:    v = RecVersion[7:0];
      5'd5:    v = RecVersion[15:8];
      5'd6:    v = RecSize[7:0];
      5'd7:    v = RecSize[15:8];
      5'd28:   v = CommitA[7:0];
      5'd29:   v = CommitA[15:8];
      5'd30:   v = CommitB[7:0];
      default: v = CommitB[15:8];
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/prc_track.sv =====
// ----------------------------------------------------------------------------
// prc_track
// Per-record state: CRC, field capture, header/commit/padding checks, and the
// status decision made on the last byte.
// ----------------------------------------------------------------------------
module prc_track import prc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  limits_t       limits_i,
  output result_t       result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     crc_q, crc_d;
  logic            header_q, header_d;
  logic            pad_q, pad_d;
  logic            commit_q, commit_d;
  logic [31:0]     gen_q, comp_q, check_q;
  logic [15:0]     freq_q, temp_q;
  logic [7:0]      mode_q;

  logic            in_rec;
  logic            is_fixed;
  logic            fixed_ok;
  logic            in_commit;
  logic            commit_ok;
  logic            is_short;
  logic            limit_bad;
  status_e         status;

  assign in_rec    = pos_q < PosW'(RecBytes);
  assign fixed_ok  = byte_i == fixed_byte(pos_q[4:0]);
  assign is_fixed  = pos_q < PosW'(8);
  assign in_commit = in_rec && (pos_q >= PosW'(28));

  // Running flags and position
  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    header_d = header_q;
    pad_d    = pad_q;
    commit_d = commit_q;
    if (take_i) begin
      if (last_i) begin
        pos_d    = '0;
        crc_d    = CrcInit;
        header_d = 1'b1;
        pad_d    = 1'b1;
        commit_d = 1'b1;
      end else if (in_rec) begin
        pos_d = pos_q + PosW'(1);
        if (pos_q < PosW'(CrcBytes)) crc_d = crc_byte(crc_q, byte_i);
        if (is_fixed && !fixed_ok) header_d = 1'b0;
        if (pos_q >= PosW'(21) && pos_q < PosW'(24) && byte_i != 8'd0) pad_d = 1'b0;
        if (in_commit && !fixed_ok) commit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= CrcInit;
      header_q <= 1'b1;
      pad_q    <= 1'b1;
      commit_q <= 1'b1;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      header_q <= header_d;
      pad_q    <= pad_d;
      commit_q <= commit_d;
    end
  end

  // Field capture; every lane is written before a full record is judged
  always_ff @(posedge clk_i) begin
    if (take_i && in_rec) begin
      if (pos_q >= PosW'(8) && pos_q < PosW'(12)) gen_q[{pos_q[1:0], 3'b000} +: 8] <= byte_i;
      if (pos_q >= PosW'(12) && pos_q < PosW'(16)) comp_q[{pos_q[1:0], 3'b000} +: 8] <= byte_i;
      if (pos_q >= PosW'(24) && pos_q < PosW'(28)) check_q[{pos_q[1:0], 3'b000} +: 8] <= byte_i;
      if (pos_q == PosW'(16)) freq_q[7:0]  <= byte_i;
      if (pos_q == PosW'(17)) freq_q[15:8] <= byte_i;
      if (pos_q == PosW'(18)) temp_q[7:0]  <= byte_i;
      if (pos_q == PosW'(19)) temp_q[15:8] <= byte_i;
      if (pos_q == PosW'(20)) mode_q       <= byte_i;
    end
  end

  // Decision on the last byte; only the commit flag and position still move
  assign is_short  = pos_q < PosW'(RecBytes - 1);
  assign commit_ok = commit_q && !(in_commit && !fixed_ok);
  assign limit_bad = (freq_q > limits_i.max_freq) ||
                     ($signed(temp_q) < limits_i.min_temp) ||
                     ($signed(temp_q) > limits_i.max_temp) ||
                     (mode_q > limits_i.max_mode);

  always_comb begin
    priority if (is_short)                        status = StBadFormat;
    else if (!commit_ok)                          status = StNotCommitted;
    else if (!header_q)                           status = StBadFormat;
    else if ((gen_q ^ comp_q) != 32'hFFFF_FFFF)   status = StBadFormat;
    else if ((crc_q ^ CrcInit) != check_q)        status = StCrcError;
    else if (!pad_q)                              status = StBadParam;
    else if (limit_bad)                           status = StBadParam;
    else                                          status = StOk;
  end

  always_comb begin
    result_o.status = status;
    if (status == StOk) begin
      result_o.frequency   = freq_q;
      result_o.temperature = $signed(temp_q);
      result_o.mode        = mode_q;
      result_o.generation  = gen_q;
    end else begin
      result_o.frequency   = '0;
      result_o.temperature = '0;
      result_o.mode        = '0;
      result_o.generation  = '0;
    end
  end

endmodule

// ===== rtl/parameter_record_checker.sv =====
// ----------------------------------------------------------------------------
// parameter_record_checker
// Checks a 32-byte CRC-32 protected parameter record, one byte per item.
// ----------------------------------------------------------------------------
// Takes one byte item per clock while input is not stalled. The byte-wide
// CRC update and field capture are registered at the edge accepting each
// byte; the last-byte verdict is formed from registered record state and
// that last byte, so a result is registered at the edge that accepts its
// last byte and offered in the next cycle if the output register is free,
// else held in the single skid entry until the output is taken. Input is
// stalled while the skid entry holds a result. Bytes past the 32nd are
// ignored until the last-byte flag. Limit registers are written through
// the cfg port (0 max frequency, 1 min temperature, 2 max temperature,
// 3 max mode); other indexes are ignored.
module parameter_record_checker import prc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  // Input item
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,
  // Result item
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [15:0]              frequency_o,
  output logic signed [15:0]       target_temperature_o,
  output logic [7:0]               control_mode_o,
  output logic [31:0]              generation_o
);

  limits_t limits_q;
  result_t result;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    in_acc, res_valid, out_fire;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.max_freq <= 16'hFFFF;
      limits_q.min_temp <= 16'sh8000;
      limits_q.max_temp <= 16'sh7FFF;
      limits_q.max_mode <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxFreq: limits_q.max_freq <= cfg_data_i;
        CfgMinTemp: limits_q.min_temp <= $signed(cfg_data_i);
        CfgMaxTemp: limits_q.max_temp <= $signed(cfg_data_i);
        CfgMaxMode: limits_q.max_mode <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign res_valid  = in_acc && last_byte_i;
  assign out_fire   = out_valid_q && !out_stall_i;

  prc_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (in_acc),
    .byte_i   (data_byte_i),
    .last_i   (last_byte_i),
    .limits_i (limits_q),
    .result_o (result)
  );

  // Output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (!out_valid_q || out_fire) begin
      if (res_valid) out_q <= result;
    end else if (res_valid) begin
      skid_q <= result;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_q.status;
  assign frequency_o          = out_q.frequency;
  assign target_temperature_o = out_q.temperature;
  assign control_mode_o       = out_q.mode;
  assign generation_o         = out_q.generation;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != StOk) |->
      (out_q.frequency == '0 && out_q.temperature == '0 &&
       out_q.mode == '0 && out_q.generation == '0))
    else $error("failed record carries nonzero fields");

  a_result_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !res_valid) |=> !out_valid_q)
    else $error("result appeared without a last byte");

endmodule

// ===== tb/sv/tb_parameter_record_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_parameter_record_checker
// Streams 32-byte parameter records into the checker, well-formed ones and
// records with damaged header, commit, generation, CRC, padding or length,
// under several limit settings, with random gaps on the byte side and random
// stalls on the verdict side. Every verdict is compared field by field with
// the one predicted for its record.
// ----------------------------------------------------------------------------
import prc_pkg::*;

// Predicts the verdict of each record and holds the verdicts still owed
class record_verdict_model;
  // limit registers
  logic        [15:0] max_freq;
  logic signed [15:0] min_temp;
  logic signed [15:0] max_temp;
  logic        [7:0]  max_mode;

  // record in progress
  int          rec_pos;
  logic [31:0] crc;
  logic        hdr_ok;
  logic [31:0] gen_word;
  logic [31:0] inv_word;
  logic [31:0] check_word;
  logic [15:0] freq_word;
  logic [15:0] temp_word;
  logic [7:0]  mode_word;
  logic        pad_ok;
  logic        commit_ok;

  // fixed bytes, little endian
  logic [63:0] header_ref;
  logic [31:0] commit_ref;

  result_t     expected_verdicts[$];
  int unsigned errors;

  function new();
    header_ref = {RecSize, RecVersion, RecMagic};
    commit_ref = {CommitB, CommitA};
    max_freq   = 16'hFFFF;
    min_temp   = 16'sh8000;
    max_temp   = 16'sh7FFF;
    max_mode   = 8'hFF;
    errors     = 0;
    clear_record();
  endfunction

  // Bit-serial reflected CRC-32, LSB of the byte first
  static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  function void clear_record();
    rec_pos    = 0;
    crc        = CrcInit;
    hdr_ok     = 1'b1;
    gen_word   = '0;
    inv_word   = '0;
    check_word = '0;
    freq_word  = '0;
    temp_word  = '0;
    mode_word  = '0;
    pad_ok     = 1'b1;
    commit_ok  = 1'b1;
  endfunction

  function void set_limit(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgMaxFreq: max_freq = data;
      CfgMinTemp: min_temp = data;
      CfgMaxTemp: max_temp = data;
      CfgMaxMode: max_mode = data[7:0];
      default: ;
    endcase
  endfunction

  // One accepted byte; on the last one the verdict is queued
  function void take_record_byte(logic [7:0] b, logic last);
    result_t v;
    int      p;
    p = rec_pos;
    // bytes past the record length are dropped
    if (p < RecBytes) begin
      if (p < CrcBytes) crc = crc_step(crc, b);
      if (p < 8) begin
        if (b != header_ref[p*8 +: 8]) hdr_ok = 1'b0;
      end else if (p < 12) begin
        gen_word[(p-8)*8 +: 8] = b;
      end else if (p < 16) begin
        inv_word[(p-12)*8 +: 8] = b;
      end else if (p < 18) begin
        freq_word[(p-16)*8 +: 8] = b;
      end else if (p < 20) begin
        temp_word[(p-18)*8 +: 8] = b;
      end else if (p == 20) begin
        mode_word = b;
      end else if (p < 24) begin
        if (b != 8'h00) pad_ok = 1'b0;
      end else if (p < 28) begin
        check_word[(p-24)*8 +: 8] = b;
      end else begin
        if (b != commit_ref[(p-28)*8 +: 8]) commit_ok = 1'b0;
      end
      rec_pos = p + 1;
    end
    if (!last) return;

    // verdict, first failing check wins
    v = '0;
    if (rec_pos < RecBytes)                   v.status = StBadFormat;
    else if (!commit_ok)                      v.status = StNotCommitted;
    else if (!hdr_ok)                         v.status = StBadFormat;
    else if ((gen_word ^ inv_word) != '1)     v.status = StBadFormat;
    else if ((crc ^ CrcInit) != check_word)   v.status = StCrcError;
    else if (!pad_ok)                         v.status = StBadParam;
    else if (freq_word > max_freq || $signed(temp_word) < min_temp ||
             $signed(temp_word) > max_temp || mode_word > max_mode)
      v.status = StBadParam;
    else                                      v.status = StOk;
    // fields only carry data on a good record
    if (v.status == StOk) begin
      v.frequency   = freq_word;
      v.temperature = temp_word;
      v.mode        = mode_word;
      v.generation  = gen_word;
    end
    expected_verdicts.push_back(v);
    clear_record();
  endfunction

  task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  task compare_verdict(result_t got);
    result_t want;
    if (expected_verdicts.size() == 0) begin
      flag_mismatch("verdict with none pending, status", 32'(got.status), 32'd0);
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.status != want.status)
      flag_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.frequency != want.frequency)
      flag_mismatch("frequency", 32'(got.frequency), 32'(want.frequency));
    if (got.temperature != want.temperature)
      flag_mismatch("temperature", 32'(got.temperature), 32'(want.temperature));
    if (got.mode != want.mode) flag_mismatch("mode", 32'(got.mode), 32'(want.mode));
    if (got.generation != want.generation)
      flag_mismatch("generation", got.generation, want.generation);
  endtask
endclass

module tb_parameter_record_checker;

  // record damage kinds, combinable
  localparam int unsigned FlawShort      = 1;
  localparam int unsigned FlawLong       = 2;
  localparam int unsigned FlawCommit     = 4;
  localparam int unsigned FlawHeader     = 8;
  localparam int unsigned FlawComplement = 16;
  localparam int unsigned FlawCrc        = 32;
  localparam int unsigned FlawPadding    = 64;
  localparam int unsigned FlawNoise      = 128;
  localparam int unsigned FlawKinds      = 8;

  localparam int unsigned QuietLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                last_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [2:0]          status_o;
  logic [15:0]         frequency_o;
  logic signed [15:0]  target_temperature_o;
  logic [7:0]          control_mode_o;
  logic [31:0]         generation_o;

  record_verdict_model verdicts;
  logic [7:0]          frame[$];
  int unsigned         in_gap_max = 3;
  int unsigned         stall_max = 3;
  int unsigned         bytes_sent;
  int unsigned         quiet_cycles = 0;

  parameter_record_checker dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Build one record in frame, then damage it as asked
  function automatic void make_record(input logic [15:0] freq, input logic [15:0] temp,
                                      input logic [7:0] mode, input logic [31:0] gen,
                                      input int unsigned flaws);
    logic [31:0] inv;
    logic [31:0] crc;
    int unsigned cut;
    inv = ~gen;
    frame.delete();
    for (int i = 0; i < 8; i++) frame.push_back(verdicts.header_ref[i*8 +: 8]);
    for (int i = 0; i < 4; i++) frame.push_back(gen[i*8 +: 8]);
    for (int i = 0; i < 4; i++) frame.push_back(inv[i*8 +: 8]);
    frame.push_back(freq[7:0]);
    frame.push_back(freq[15:8]);
    frame.push_back(temp[7:0]);
    frame.push_back(temp[15:8]);
    frame.push_back(mode);
    repeat (3) frame.push_back(8'h00);
    // damage covered by the CRC
    if ((flaws & FlawHeader) != 0) frame[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
    if ((flaws & FlawComplement) != 0)
      frame[$urandom_range(8, 15)] ^= 8'($urandom_range(1, 255));
    if ((flaws & FlawPadding) != 0)
      frame[$urandom_range(21, 23)] ^= 8'($urandom_range(1, 255));
    crc = CrcInit;
    for (int i = 0; i < CrcBytes; i++) crc = verdicts.crc_step(crc, frame[i]);
    crc = crc ^ CrcInit;
    for (int i = 0; i < 4; i++) frame.push_back(crc[i*8 +: 8]);
    for (int i = 0; i < 4; i++) frame.push_back(verdicts.commit_ref[i*8 +: 8]);
    // damage applied after the CRC is computed
    if ((flaws & FlawCrc) != 0) frame[$urandom_range(24, 27)] ^= 8'($urandom_range(1, 255));
    if ((flaws & FlawCommit) != 0) frame[$urandom_range(28, 31)] ^= 8'($urandom_range(1, 255));
    if ((flaws & FlawNoise) != 0) foreach (frame[i]) frame[i] = 8'($urandom);
    if ((flaws & FlawLong) != 0) repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
    if ((flaws & FlawShort) != 0) begin
      cut = $urandom_range(1, RecBytes - 1);
      while (frame.size() > cut) void'(frame.pop_back());
    end
  endfunction

  // Send frame, last flag on its final byte, random gap before each item unless sent as a burst
  task automatic send_frame();
    int unsigned gap;
    bit          burst;
    logic        last;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < frame.size(); i++) begin
      gap  = burst ? 0 : $urandom_range(0, in_gap_max);
      last = (i == frame.size() - 1);
      @(negedge clk_i);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= frame[i];
      last_byte_i <= last;
      do @(posedge clk_i); while (in_stall_o);
      verdicts.take_record_byte(frame[i], last);
    end
    bytes_sent += (frame.size() > RecBytes) ? RecBytes : frame.size();
  endtask

  // Quiet input and all verdicts collected
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdicts.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    verdicts.set_limit(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_limits(input logic [15:0] f, input logic [15:0] lo,
                              input logic [15:0] hi, input logic [7:0] m);
    wait_idle();
    write_reg(CfgMaxFreq, f);
    write_reg(CfgMinTemp, lo);
    write_reg(CfgMaxTemp, hi);
    write_reg(CfgMaxMode, {8'($urandom), m});
    // stray write to an unmapped index now and then
    if ($urandom_range(0, 2) == 0)
      write_reg(CfgIdxW'($urandom_range(CfgMaxMode + 1, (1 << CfgIdxW) - 1)),
                16'($urandom));
  endtask

  // Verdict receiver: random stall before each verdict
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      hold = $urandom_range(0, stall_max);
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Verdict monitor
  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.status      = status_e'(status_o);
      seen.frequency   = frequency_o;
      seen.temperature = target_temperature_o;
      seen.mode        = control_mode_o;
      seen.generation  = generation_o;
      verdicts.compare_verdict(seen);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] f;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] t;
    logic [7:0]  m;
    logic [31:0] g;
    int unsigned flaws;
    verdicts    = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes under reset limits
    make_record(16'hFFFF, 16'h8000, 8'hFF, 32'hFFFF_FFFF, 0);
    send_frame();
    make_record(16'h0000, 16'h7FFF, 8'h00, 32'h0000_0000, 0);
    send_frame();
    // one-byte record, then short, long and each damaged field
    frame = {8'h56};
    send_frame();
    make_record(16'h1234, 16'h0042, 8'h07, 32'h0000_0001, FlawShort);
    send_frame();
    make_record(16'h1234, 16'hFF9C, 8'h07, 32'h8000_0000, FlawLong);
    send_frame();
    make_record(16'h0100, 16'h0000, 8'h01, 32'h0000_0005, FlawCommit);
    send_frame();
    make_record(16'h0100, 16'h0000, 8'h01, 32'h0000_0006, FlawCommit | FlawHeader);
    send_frame();
    make_record(16'h0100, 16'h0000, 8'h01, 32'h0000_0007, FlawHeader);
    send_frame();
    make_record(16'h0100, 16'h0000, 8'h01, 32'h0000_0008, FlawComplement);
    send_frame();
    make_record(16'h0100, 16'h0000, 8'h01, 32'h0000_0009, FlawCrc);
    send_frame();
    make_record(16'h0100, 16'h0000, 8'h01, 32'h0000_000A, FlawPadding);
    send_frame();
    make_record(16'h0100, 16'h0000, 8'h01, 32'h0000_000B, FlawPadding | FlawCrc);
    send_frame();

    // Directed: tight limits, on and just past each edge
    apply_limits(16'd100, -16'sd50, 16'sd50, 8'd3);
    make_record(16'd100, -16'sd50, 8'd3, 32'h0000_0010, 0);
    send_frame();
    make_record(16'd101, 16'sd0, 8'd0, 32'h0000_0011, 0);
    send_frame();
    make_record(16'd0, -16'sd51, 8'd0, 32'h0000_0012, 0);
    send_frame();
    make_record(16'd0, 16'sd51, 8'd0, 32'h0000_0013, 0);
    send_frame();
    make_record(16'd0, 16'sd50, 8'd4, 32'h0000_0014, 0);
    send_frame();
    // unmapped index leaves the limits alone
    wait_idle();
    write_reg(CfgIdxW'(CfgMaxMode + 1), 16'h0000);
    make_record(16'd100, 16'sd50, 8'd3, 32'h0000_0015, 0);
    send_frame();
    // inverted temperature window rejects every temperature
    apply_limits(16'hFFFF, 16'sd10, -16'sd10, 8'hFF);
    make_record(16'd0, 16'sd0, 8'd0, 32'h0000_0016, 0);
    send_frame();
    make_record(16'd0, 16'sd10, 8'd0, 32'h0000_0017, 0);
    send_frame();

    // Random phases: new limits and idle profile, then a batch of records
    bytes_sent = 0;
    while (bytes_sent < 400) begin
      f  = 16'($urandom);
      lo = 16'($urandom);
      hi = 16'($urandom);
      m  = 8'($urandom);
      case ($urandom_range(0, 4))
        0: begin f = 16'hFFFF; lo = 16'h8000; hi = 16'h7FFF; m = 8'hFF; end
        1: begin f = 16'h0000; lo = 16'h0000; hi = 16'h0000; m = 8'h00; end
        2: begin
          // mostly an ordered window
          if ($urandom_range(0, 3) != 0 && $signed(lo) > $signed(hi)) begin
            t = lo; lo = hi; hi = t;
          end
        end
        3: begin lo = 16'($urandom_range(1, 32767)); hi = -lo; end
        default: begin f = 16'h0000; lo = 16'h7FFF; hi = 16'h7FFF; m = 8'h00; end
      endcase
      apply_limits(f, lo, hi, m);
      case ($urandom_range(0, 2))
        0: in_gap_max = 0;
        1: in_gap_max = 2;
        default: in_gap_max = 12;
      endcase
      case ($urandom_range(0, 2))
        0: stall_max = 0;
        1: stall_max = 2;
        default: stall_max = 12;
      endcase

      repeat (6) begin
        case ($urandom_range(0, 5))
          0: f = verdicts.max_freq;
          1: f = 16'(verdicts.max_freq + 16'd1);
          2: f = 16'h0000;
          3: f = 16'hFFFF;
          default: f = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0: t = verdicts.min_temp;
          1: t = verdicts.max_temp;
          2: t = 16'(verdicts.min_temp - 16'sd1);
          3: t = 16'(verdicts.max_temp + 16'sd1);
          4: t = 16'h8000;
          5: t = 16'h7FFF;
          default: t = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0: m = verdicts.max_mode;
          1: m = 8'(verdicts.max_mode + 8'd1);
          2: m = 8'h00;
          default: m = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0: g = 32'h0000_0000;
          1: g = 32'hFFFF_FFFF;
          default: g = $urandom;
        endcase
        // mostly well-formed records, the rest damaged
        flaws = 0;
        if ($urandom_range(0, 99) >= 55) begin
          flaws = 1 << $urandom_range(0, FlawKinds - 1);
          if ($urandom_range(0, 9) == 0) flaws |= 1 << $urandom_range(0, FlawKinds - 1);
        end
        make_record(f, t, m, g, flaws);
        send_frame();
      end
    end

    // Drain and let the pipeline settle
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (verdicts.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
